// ----- rtl/multi_channel_debounce_router_macros.svh -----
// Assertion macros shared by the debounce router checker.
`ifndef MULTI_CHANNEL_DEBOUNCE_ROUTER_MACROS_SVH
`define MULTI_CHANNEL_DEBOUNCE_ROUTER_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define MCDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked property that also holds during reset.
`define MCDR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/mcdr_pkg.sv -----
// Shared constants and types for the multi-channel debounce router.
package mcdr_pkg;

  localparam int unsigned ChannelsDef = 7;
  localparam int unsigned PinW        = 7;
  localparam int unsigned DelayW      = 5;
  localparam int unsigned CodeW       = 4;
  localparam int unsigned CfgDataW    = 7;
  localparam int unsigned TDataInW    = 8;
  localparam int unsigned TDataOutW   = 8;

  localparam logic [DelayW-1:0] DelayReset = 5'd25;
  localparam logic [PinW-1:0]   MaskReset  = 7'd0;

  // Register indexes on the configuration channel
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t RegDebounceDelay = 1'b0;
  localparam cfg_idx_t RegPressedMask   = 1'b1;

  // Channel roles
  localparam logic [2:0] ChActivate   = 3'd2;
  localparam logic [2:0] ChMenuIter   = 3'd3;
  localparam logic [2:0] ChMenuAccept = 3'd4;
  localparam logic [2:0] ChDeactivate = 3'd6;

  // Event codes beyond press and release
  localparam logic [CodeW-1:0] CodeWakeUp = 4'd14;
  localparam logic [CodeW-1:0] CodeSleep  = 4'd15;

  // Sinks
  localparam logic DestSystem = 1'b0;
  localparam logic DestSetUp  = 1'b1;

  typedef struct packed {
    logic             dest;
    logic [CodeW-1:0] code;
  } event_t;

endpackage

// ----- rtl/multi_channel_debounce_router.sv -----
// Multi-channel debouncer with routed press and release events.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------------
//  s_axis   | in        | tvalid / tready      | tdata: pin_levels
//  m_axis   | out       | tvalid / tready      | tdata: event_code, tuser: dest, tlast
//  cfg      | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  A tick runs through the input take, a visit of each channel, a second-event step
//  for each channel with a second event, and a flush; the shared channel update unit
//  visits one channel per cycle but stalls on m_axis only when an event
//  waits behind a full output register. Reset returns every channel to up with a
//  zero countdown and restores the register defaults; no clearing pass follows.
module multi_channel_debounce_router #(
  parameter int unsigned CHANNELS = mcdr_pkg::ChannelsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [mcdr_pkg::TDataInW-1:0]   s_axis_tdata_i,  // [6:0] pin_levels
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [mcdr_pkg::TDataOutW-1:0]  m_axis_tdata_o,  // [3:0] event_code
  output logic                            m_axis_tuser_o,  // [0] destination
  output logic                            m_axis_tlast_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  mcdr_pkg::cfg_idx_t              cfg_index_i,
  input  logic [mcdr_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [ChW-1:0] ChLast = ChW'(CHANNELS - 1);

  typedef enum logic [1:0] {
    CH_UP      = 2'd0,
    CH_FALLING = 2'd1,
    CH_DOWN    = 2'd2,
    CH_RISING  = 2'd3
  } chst_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_VISIT,
    S_SECOND,
    S_FLUSH
  } seq_e;

  seq_e                            seq_q;
  logic [ChW-1:0]                  ch_q;
  logic [mcdr_pkg::PinW-1:0]       levels_q;
  logic [mcdr_pkg::DelayW-1:0]     delay_q;
  logic [mcdr_pkg::PinW-1:0]       mask_q;
  chst_e                           chst_q [CHANNELS];
  logic [mcdr_pkg::DelayW-1:0]     cnt_q  [CHANNELS];

  logic                            pend_valid_q;
  mcdr_pkg::event_t                pend_q;
  logic                            out_valid_q;
  mcdr_pkg::event_t                out_q;
  logic                            out_last_q;

  // Shared channel update unit
  logic                            pressed;
  chst_e                           st_cur, st_d;
  logic [mcdr_pkg::DelayW-1:0]     cnt_cur, cnt_d;
  logic                            cnt_zero;
  logic [2:0]                      ch_id;
  logic                            is_menu;
  logic                            ev1_valid, ev2_need;
  mcdr_pkg::event_t                ev1, ev2;
  logic                            out_free, stall, ch_is_last;
  logic                            out_load, out_last_d;

  assign ch_id    = 3'(ch_q);
  assign pressed  = (levels_q[ch_q] == mask_q[ch_q]);
  assign st_cur   = chst_q[ch_q];
  assign cnt_cur  = cnt_q[ch_q];
  assign cnt_zero = (cnt_cur == '0);
  assign is_menu  = (ch_id == mcdr_pkg::ChMenuIter) || (ch_id == mcdr_pkg::ChMenuAccept);

  always_comb begin
    st_d      = st_cur;
    cnt_d     = cnt_cur;
    ev1_valid = 1'b0;
    ev2_need  = 1'b0;
    ev1.dest  = is_menu ? mcdr_pkg::DestSetUp : mcdr_pkg::DestSystem;
    ev1.code  = {ch_id, 1'b0};
    ev2.dest  = mcdr_pkg::DestSetUp;
    ev2.code  = (ch_id == mcdr_pkg::ChDeactivate) ? mcdr_pkg::CodeWakeUp
                                                  : mcdr_pkg::CodeSleep;
    unique case (st_cur)
      CH_UP: begin
        if (pressed) begin
          st_d  = CH_FALLING;
          cnt_d = delay_q;
        end
      end
      CH_FALLING: begin
        if (!cnt_zero) begin
          cnt_d = cnt_cur - 1'b1;
        end else if (!pressed) begin
          st_d = CH_UP;
        end else begin
          st_d      = CH_DOWN;
          ev1_valid = 1'b1;
          ev1.code  = {ch_id, 1'b1};
          ev2_need  = (ch_id == mcdr_pkg::ChActivate) || (ch_id == mcdr_pkg::ChDeactivate);
        end
      end
      CH_DOWN: begin
        if (!pressed) begin
          st_d  = CH_RISING;
          cnt_d = delay_q;
        end
      end
      CH_RISING: begin
        if (!cnt_zero) begin
          cnt_d = cnt_cur - 1'b1;
        end else if (!pressed) begin
          st_d      = CH_UP;
          ev1_valid = 1'b1;
        end else begin
          st_d = CH_DOWN;
        end
      end
      default: st_d = CH_UP;
    endcase
  end

  assign out_free   = !out_valid_q || m_axis_tready_i;
  assign stall      = ev1_valid && pend_valid_q && !out_free;
  assign ch_is_last = (ch_q == ChLast);

  // The output register is only ever loaded from the pending slot
  always_comb begin
    unique case (seq_q)
      S_IDLE:   out_load = 1'b0;
      S_VISIT:  out_load = !stall && ev1_valid && pend_valid_q;
      S_SECOND: out_load = out_free;
      S_FLUSH:  out_load = pend_valid_q && out_free;
    endcase
  end

  assign out_last_d = (seq_q == S_FLUSH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q        <= S_IDLE;
      ch_q         <= '0;
      levels_q     <= '0;
      delay_q      <= mcdr_pkg::DelayReset;
      mask_q       <= mcdr_pkg::MaskReset;
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      out_last_q   <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        chst_q[i] <= CH_UP;
        cnt_q[i]  <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          mcdr_pkg::RegDebounceDelay: delay_q <= cfg_data_i[mcdr_pkg::DelayW-1:0];
          mcdr_pkg::RegPressedMask:   mask_q  <= cfg_data_i[mcdr_pkg::PinW-1:0];
          default: ;
        endcase
      end

      // load the pending event, else drop the output once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q       <= pend_q;
        out_last_q  <= out_last_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (seq_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            levels_q <= s_axis_tdata_i[mcdr_pkg::PinW-1:0];
            ch_q     <= '0;
            seq_q    <= S_VISIT;
          end
        end
        S_VISIT: begin
          if (!stall) begin
            chst_q[ch_q] <= st_d;
            cnt_q[ch_q]  <= cnt_d;
            if (ev1_valid) begin
              pend_valid_q <= 1'b1;
              pend_q       <= ev1;
            end
            if (ev2_need) begin
              seq_q <= S_SECOND;
            end else if (ch_is_last) begin
              seq_q <= S_FLUSH;
            end else begin
              ch_q <= ch_q + 1'b1;
            end
          end
        end
        S_SECOND: begin
          // the press of this channel sits in the pending slot; push it on
          if (out_free) begin
            pend_q <= ev2;
            if (ch_is_last) begin
              seq_q <= S_FLUSH;
            end else begin
              ch_q  <= ch_q + 1'b1;
              seq_q <= S_VISIT;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid_q) begin
            seq_q <= S_IDLE;
          end else if (out_free) begin
            pend_valid_q <= 1'b0;
            seq_q        <= S_IDLE;
          end
        end
        default: seq_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (seq_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = mcdr_pkg::TDataOutW'(out_q.code);
  assign m_axis_tuser_o  = out_q.dest;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ----- rtl/mcdr_checker.sv -----
// Port-level checker for the debounce router, bound to the top level.
`include "multi_channel_debounce_router_macros.svh"

module mcdr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [mcdr_pkg::TDataOutW-1:0] m_axis_tdata_o,
  input logic                           m_axis_tuser_o,
  input logic                           m_axis_tlast_o
);

  logic                               out_busy;
  logic                               in_take;
  logic                               wake_or_sleep;
  logic [mcdr_pkg::TDataOutW+1:0]     out_word;

  assign out_busy      = m_axis_tvalid_o && !m_axis_tready_i;
  assign in_take       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_word      = {m_axis_tlast_o, m_axis_tuser_o, m_axis_tdata_o};
  assign wake_or_sleep = m_axis_tvalid_o &&
                         ((m_axis_tdata_o[mcdr_pkg::CodeW-1:0] == mcdr_pkg::CodeWakeUp) ||
                          (m_axis_tdata_o[mcdr_pkg::CodeW-1:0] == mcdr_pkg::CodeSleep));

  // a waiting event must hold until taken
  `MCDR_ASSERT(a_out_hold, out_busy |=> m_axis_tvalid_o && $stable(out_word), "stalled event changed")

  // the input is not ready in the cycle after a tick is taken
  `MCDR_ASSERT(a_busy_after_tick, in_take |=> !s_axis_tready_o, "input ready right after a tick")

  // wake-up and sleep only go to the set-up sink
  `MCDR_ASSERT(a_wake_sleep_route, wake_or_sleep |-> m_axis_tuser_o == mcdr_pkg::DestSetUp, "bad route")

  // no event during reset
  `MCDR_ASSERT_RST(a_reset_quiet, !rst_ni |-> !m_axis_tvalid_o, "event valid during reset")

endmodule

bind multi_channel_debounce_router mcdr_checker u_mcdr_checker (.*);

// ----- verif/debounce_check_pkg.sv -----
`timescale 1ns / 1ps
// Event predictor and scoreboard for the debounce router testbench.
package debounce_check_pkg;
  import mcdr_pkg::*;

  typedef enum logic [1:0] {KeyUp, KeyFalling, KeyDown, KeyRising} key_state_e;

  typedef struct packed {
    logic             dest;
    logic [CodeW-1:0] code;
    logic             last;
  } routed_event_t;

  class debounce_scoreboard;
    logic [DelayW-1:0] debounce_ticks;
    logic [PinW-1:0]   pressed_mask;
    key_state_e        key_state[ChannelsDef];
    logic [DelayW-1:0] countdown[ChannelsDef];
    routed_event_t     expected_events[$];
    routed_event_t     tick_events[$];
    int                errors;

    function new();
      debounce_ticks = DelayReset;
      pressed_mask   = MaskReset;
      errors         = 0;
      foreach (key_state[i]) begin
        key_state[i] = KeyUp;
        countdown[i] = '0;
      end
    endfunction

    function void set_register(cfg_idx_t idx, logic [CfgDataW-1:0] value);
      if (idx == RegDebounceDelay) begin
        debounce_ticks = value[DelayW-1:0];
      end else begin
        pressed_mask = value[PinW-1:0];
      end
    endfunction

    function void push_event(logic dest, logic [CodeW-1:0] code);
      routed_event_t ev;
      ev.dest = dest;
      ev.code = code;
      ev.last = 1'b0;
      tick_events.push_back(ev);
    endfunction

    // Advance every channel by one tick and queue the events it routes.
    function void note_tick(logic [PinW-1:0] pins);
      logic hit;
      logic menu;
      tick_events.delete();
      for (int ch = 0; ch < ChannelsDef; ch++) begin
        hit  = (pins[ch] == pressed_mask[ch]);
        menu = (ch == ChMenuIter) || (ch == ChMenuAccept);
        unique case (key_state[ch])
          KeyUp: begin
            if (hit) begin
              countdown[ch] = debounce_ticks;
              key_state[ch] = KeyFalling;
            end
          end
          KeyFalling: begin
            if (countdown[ch] != 0) begin
              countdown[ch] = countdown[ch] - 1'b1;
            end else if (!hit) begin
              key_state[ch] = KeyUp;
            end else begin
              push_event(menu ? DestSetUp : DestSystem, CodeW'(2 * ch + 1));
              if (ch == ChDeactivate) push_event(DestSetUp, CodeWakeUp);
              else if (ch == ChActivate) push_event(DestSetUp, CodeSleep);
              key_state[ch] = KeyDown;
            end
          end
          KeyDown: begin
            if (!hit) begin
              countdown[ch] = debounce_ticks;
              key_state[ch] = KeyRising;
            end
          end
          default: begin
            if (countdown[ch] != 0) begin
              countdown[ch] = countdown[ch] - 1'b1;
            end else if (!hit) begin
              push_event(menu ? DestSetUp : DestSystem, CodeW'(2 * ch));
              key_state[ch] = KeyUp;
            end else begin
              key_state[ch] = KeyDown;
            end
          end
        endcase
      end
      if (tick_events.size() > 0) tick_events[tick_events.size() - 1].last = 1'b1;
      foreach (tick_events[i]) expected_events.push_back(tick_events[i]);
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    task report_mismatch(input string what);
      errors++;
      $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_event(input logic dest, input logic [TDataOutW-1:0] data, input logic last);
      routed_event_t want;
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("event with none expected: dest %0d data %0h last %0d",
                                  dest, data, last));
        return;
      end
      want = expected_events.pop_front();
      if (dest !== want.dest)
        report_mismatch($sformatf("destination %0d, expected %0d (code %0d)",
                                  dest, want.dest, want.code));
      if (data !== TDataOutW'(want.code))
        report_mismatch($sformatf("data %0h, expected code %0d", data, want.code));
      if (last !== want.last)
        report_mismatch($sformatf("last %0d, expected %0d (code %0d)",
                                  last, want.last, want.code));
    endtask
  endclass

endpackage

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Top-level testbench for the multi-channel debounce router.
module tb_top;
  import mcdr_pkg::*;
  import debounce_check_pkg::*;

  localparam int StallLimit   = 2000;
  localparam int SettleCycles = 30;
  localparam int HoldOffLen   = 400;
  localparam int PhaseCount   = 8;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b1;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [TDataInW-1:0]  s_axis_tdata_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [TDataOutW-1:0] m_axis_tdata_o;
  logic                 m_axis_tuser_o;
  logic                 m_axis_tlast_o;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  cfg_idx_t             cfg_index_i     = RegDebounceDelay;
  logic [CfgDataW-1:0]  cfg_data_i      = '0;

  debounce_scoreboard sb;
  logic steady          = 1'b0;
  logic holdoff_pending = 1'b0;
  int   quiet_cycles    = 0;

  multi_channel_debounce_router dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  task automatic send_tick(input logic [PinW-1:0] pins);
    while (!steady && $urandom_range(0, 99) < 28) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= TDataInW'(pins);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_tick(pins);
  endtask

  task automatic configure(input logic [CfgDataW-1:0] delay_val,
                           input logic [CfgDataW-1:0] mask_val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= RegDebounceDelay;
    cfg_data_i  <= delay_val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_register(RegDebounceDelay, delay_val);
    cfg_index_i <= RegPressedMask;
    cfg_data_i  <= mask_val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_register(RegPressedMask, mask_val);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold the input until every expected event is out, then let a tick finish.
  task automatic drain_events();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Mostly levels held long enough to confirm, with short bounces and glitches.
  task automatic run_phase(input int items, input int dly);
    logic [PinW-1:0] level;
    int hold;
    int sent;
    level = $urandom_range(0, 127);
    sent  = 0;
    while (sent < items) begin
      level = level ^ PinW'($urandom_range(1, 127));
      if ($urandom_range(0, 99) < 80) hold = dly + 2 + $urandom_range(0, 3);
      else hold = $urandom_range(1, dly + 1);
      for (int k = 0; k < hold && sent < items; k++) begin
        if ($urandom_range(0, 99) < 8) send_tick(level ^ (PinW'(1) << $urandom_range(0, 6)));
        else send_tick(level);
        sent++;
      end
    end
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (holdoff_pending) begin
        holdoff_pending = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HoldOffLen) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= steady || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_event(m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [PinW-1:0] zero_delay_seq[14];
    logic [PinW-1:0] one_delay_seq[9];
    logic [CfgDataW-1:0] delay_val;
    logic [CfgDataW-1:0] mask_val;
    int items;
    // Assert reset with a falling edge so the block clears at once
    rst_ni <= 1'b0;
    // Press all, release all, abandoned press, abandoned release
    zero_delay_seq = '{7'h00, 7'h00, 7'h7f, 7'h7f, 7'h00, 7'h7f, 7'h7f,
                       7'h00, 7'h00, 7'h7f, 7'h00, 7'h00, 7'h7f, 7'h7f};
    // Inverted polarity, split channel groups bouncing against each other
    one_delay_seq  = '{7'h7f, 7'h7f, 7'h7f, 7'h55, 7'h55, 7'h2a, 7'h00, 7'h00, 7'h00};
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(7'd0, 7'h00);
    foreach (zero_delay_seq[i]) send_tick(zero_delay_seq[i]);
    drain_events();
    // Delay value above five bits: only the low bits count
    configure(7'h21, 7'h7f);
    foreach (one_delay_seq[i]) send_tick(one_delay_seq[i]);
    drain_events();

    for (int p = 0; p < PhaseCount; p++) begin
      mask_val = $urandom_range(0, 127);
      items    = 50;
      case (p)
        0: begin delay_val = 7'd57; mask_val = 7'h00; items = 60; end
        1: begin delay_val = 7'd0; mask_val = 7'h7f; items = 60; steady = 1'b1; end
        2: begin delay_val = 7'd31; items = 70; end
        3: delay_val = 7'd1;
        4: begin delay_val = 7'd2; mask_val = 7'h2a; items = 60; end
        5: delay_val = 7'h63;
        6: begin delay_val = CfgDataW'($urandom_range(0, 6)); mask_val = 7'h55; end
        default: begin delay_val = 7'd0; items = 60; end
      endcase
      configure(delay_val, mask_val);
      // Starve the output so the block backs up onto its input
      if (p == 3) holdoff_pending = 1'b1;
      if (p == 4) begin
        run_phase(30, delay_val[DelayW-1:0]);
        drain_events();
        run_phase(items - 30, delay_val[DelayW-1:0]);
      end else begin
        run_phase(items, delay_val[DelayW-1:0]);
      end
      drain_events();
      steady = 1'b0;
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
